### design/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg: shared types and helpers for the buddy block allocator
// Node mark codes, command and status codes, sequencer states, the item and
// result beats passed between the allocator modules, and size rounding.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Largest pool order; the mark tree holds 2^(MAX_ORDER+1) - 1 nodes
  localparam int MAX_ORDER = 10;
  localparam int NODE_AW   = MAX_ORDER + 1;
  localparam int ORD_W     = 4;
  localparam int OFS_W     = 10;
  localparam int SIZE_W    = 11;

  typedef enum logic [1:0] {
    MK_ABSENT = 2'd0,
    MK_FREE   = 2'd1,
    MK_USED   = 2'd2,
    MK_SPLIT  = 2'd3
  } bba_mark_t;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } bba_cmd_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_NOFIT  = 2'd1,
    STS_BADREL = 2'd2
  } bba_status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC_RD,
    ST_ALLOC_SPLIT,
    ST_ALLOC_SIB,
    ST_ALLOC_USE,
    ST_ALLOC_CLIMB,
    ST_REL_RD,
    ST_REL_FREE,
    ST_REL_MERGE,
    ST_REL_PRUNE,
    ST_DONE
  } bba_state_t;

  // One command beat as seen by the sequencer
  typedef struct packed {
    bba_cmd_t           cmd;
    logic [ORD_W-1:0]   req;
    logic [OFS_W-1:0]   roff;
  } bba_item_t;

  // One result beat
  typedef struct packed {
    bba_status_t        status;
    logic [OFS_W-1:0]   offset;
    logic [ORD_W-1:0]   order;
  } bba_res_t;

  // Round a size up to a power of two and return its log2 (zero counts as one)
  function automatic logic [ORD_W-1:0] size_order(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] s1;
    logic [ORD_W-1:0]  r;
    s1 = (size == '0) ? '0 : size - SIZE_W'(1);
    r  = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (s1[i]) begin
        r = ORD_W'(i + 1);
      end
    end
    return r;
  endfunction

endpackage

### design/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator: buddy allocator over a pool of 2^pool_order units
// Allocates power-of-two blocks first fit in address order and releases them
// with buddy merging; node marks of the tree live in one RAM.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_valid/cfg_ready  pool_order
//   in       in         in_valid/in_stall    command, request_size, release_offset
//   out      out        out_valid/out_stall  status, block_offset, block_order
//
// One command at a time. An allocate reads tree nodes, steps sideways or
// upward and splits one level at a time; a release reads up to pool_order + 1
// nodes on the way down, then frees, merges and prunes level by level.
// Reset and every pool_order write run a sweep over the mark RAM;
// no command is taken during it. A held result in the output register does
// not block the next command; a finished one waits for out_stall to drop.
// ----------------------------------------------------------------------------
module buddy_block_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  pool_order,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [10:0] request_size,
  input  logic [9:0]  release_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [9:0]  block_offset,
  output logic [3:0]  block_order
);

  import bba_pkg::*;

  logic [ORD_W-1:0] pool_lvl;
  logic             cfg_write;
  logic             seq_ready;
  logic             seq_cfg_ok;
  logic             res_valid;
  logic             res_ready;
  bba_item_t        item;
  bba_res_t         res;

  assign cfg_ready = seq_cfg_ok;
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_stall  = !seq_ready;

  // Pack the command beat; round the size to an order up front
  assign item.cmd  = bba_cmd_t'(command);
  assign item.req  = size_order(request_size);
  assign item.roff = release_offset;

  // Pool order register, clamped to the tree depth
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_lvl <= ORD_W'(MAX_ORDER);
    end else if (cfg_write) begin
      pool_lvl <= (pool_order > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : pool_order;
    end
  end

  bba_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .pool_lvl   (pool_lvl),
    .restart    (cfg_write),
    .ready      (seq_ready),
    .cfg_ok     (seq_cfg_ok),
    .item_valid (in_valid),
    .item       (item),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  // Output register: load a new beat when empty or being drained
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status       <= res.status;
      block_offset <= res.offset;
      block_order  <= res.order;
    end
  end

endmodule

### design/bba_mark_ram.sv
// ----------------------------------------------------------------------------
// bba_mark_ram: simple dual-port RAM for node marks
// One write port and one read port; read data registered.
// A read and a write to the same entry in one cycle returns the old value.
// ----------------------------------------------------------------------------
module bba_mark_ram #(
  parameter int AW = 11,
  parameter int DW = 2
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/bba_seq.sv
// ----------------------------------------------------------------------------
// bba_seq: tree walk sequencer of the buddy block allocator
// Owns the mark RAM. Clears it after reset or a pool change, walks the tree
// in address order for an allocate, descends to the leaf and merges buddies
// upward for a release, and holds the result until the output side takes it.
// ----------------------------------------------------------------------------
module bba_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [3:0]               pool_lvl,
  input  logic                     restart,
  output logic                     ready,
  output logic                     cfg_ok,
  input  logic                     item_valid,
  input  bba_pkg::bba_item_t       item,
  output logic                     res_valid,
  output bba_pkg::bba_res_t        res,
  input  logic                     res_ready
);

  import bba_pkg::*;

  bba_state_t          state, state_next;
  logic [NODE_AW-1:0]  node, node_next;
  logic [ORD_W-1:0]    lvl, lvl_next;
  logic [NODE_AW-1:0]  base, base_next;
  logic [NODE_AW-1:0]  clr_cnt, clr_cnt_next;
  bba_item_t           cur, cur_next;
  bba_res_t            res_next;

  logic                we, re;
  logic [NODE_AW-1:0]  waddr, raddr;
  logic [1:0]          wdata, rdata;

  logic [NODE_AW-1:0]  node_left, node_right, node_up, node_buddy, node_succ;
  logic [ORD_W-1:0]    lvl_dec;
  logic [NODE_AW-1:0]  lvl_span;
  logic [OFS_W-1:0]    low_mask;
  logic                roff_in_pool;
  logic                take;

  bba_mark_ram #(.AW(NODE_AW), .DW(2)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Tree index arithmetic
  assign node_left    = {node[NODE_AW-2:0], 1'b0};
  assign node_right   = {node[NODE_AW-2:0], 1'b1};
  assign node_up      = {1'b0, node[NODE_AW-1:1]};
  assign node_buddy   = {node[NODE_AW-1:1], ~node[0]};
  assign node_succ    = node + NODE_AW'(1);
  assign lvl_dec      = lvl - ORD_W'(1);
  assign lvl_span     = NODE_AW'(1) << lvl;
  assign low_mask     = OFS_W'(lvl_span - NODE_AW'(1));
  assign roff_in_pool = NODE_AW'(item.roff) < (NODE_AW'(1) << pool_lvl);

  assign ready     = (state == ST_IDLE) && !restart;
  assign cfg_ok    = (state == ST_IDLE) || (state == ST_CLEAR);
  assign take      = ready && item_valid;
  assign res_valid = (state == ST_DONE);

  // Next state, RAM accesses and result
  always_comb begin
    state_next   = state;
    node_next    = node;
    lvl_next     = lvl;
    base_next    = base;
    clr_cnt_next = clr_cnt;
    cur_next     = cur;
    res_next     = res;
    we           = 1'b0;
    waddr        = node;
    wdata        = MK_ABSENT;
    re           = 1'b0;
    raddr        = node;

    unique case (state)
      ST_CLEAR: begin
        // sweep every entry; node 1 becomes the free root
        we           = 1'b1;
        waddr        = clr_cnt;
        wdata        = (clr_cnt == NODE_AW'(1)) ? MK_FREE : MK_ABSENT;
        clr_cnt_next = clr_cnt + NODE_AW'(1);
        if (clr_cnt == '1) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (take) begin
          cur_next  = item;
          node_next = NODE_AW'(1);
          lvl_next  = pool_lvl;
          base_next = '0;
          if (item.cmd == CMD_ALLOC) begin
            if (item.req > pool_lvl) begin
              res_next   = '{status: STS_NOFIT, offset: '0, order: item.req};
              state_next = ST_DONE;
            end else begin
              re         = 1'b1;
              raddr      = NODE_AW'(1);
              state_next = ST_ALLOC_RD;
            end
          end else begin
            if (roff_in_pool) begin
              re         = 1'b1;
              raddr      = NODE_AW'(1);
              state_next = ST_REL_RD;
            end else begin
              res_next   = '{status: STS_BADREL, offset: item.roff, order: '0};
              state_next = ST_DONE;
            end
          end
        end
      end

      ST_ALLOC_RD: begin
        // descend left through split nodes, then test the leaf
        if (rdata == MK_SPLIT && lvl != '0) begin
          node_next = node_left;
          lvl_next  = lvl_dec;
          re        = 1'b1;
          raddr     = node_left;
        end else if (rdata == MK_FREE && lvl >= cur.req) begin
          state_next = (lvl == cur.req) ? ST_ALLOC_USE : ST_ALLOC_SPLIT;
        end else begin
          base_next  = base + lvl_span;
          state_next = ST_ALLOC_CLIMB;
        end
      end

      ST_ALLOC_SPLIT: begin
        we         = 1'b1;
        waddr      = node;
        wdata      = MK_SPLIT;
        state_next = ST_ALLOC_SIB;
      end

      ST_ALLOC_SIB: begin
        // free the upper half, move into the lower half
        we         = 1'b1;
        waddr      = node_right;
        wdata      = MK_FREE;
        node_next  = node_left;
        lvl_next   = lvl_dec;
        state_next = (lvl_dec == cur.req) ? ST_ALLOC_USE : ST_ALLOC_SPLIT;
      end

      ST_ALLOC_USE: begin
        we         = 1'b1;
        waddr      = node;
        wdata      = MK_USED;
        res_next   = '{status: STS_OK, offset: base[OFS_W-1:0], order: cur.req};
        state_next = ST_DONE;
      end

      ST_ALLOC_CLIMB: begin
        // step to the next subtree in address order; back at the root means full
        if (node == NODE_AW'(1)) begin
          res_next   = '{status: STS_NOFIT, offset: '0, order: cur.req};
          state_next = ST_DONE;
        end else if (node[0]) begin
          node_next = node_up;
          lvl_next  = lvl + ORD_W'(1);
        end else begin
          node_next  = node_succ;
          re         = 1'b1;
          raddr      = node_succ;
          state_next = ST_ALLOC_RD;
        end
      end

      ST_REL_RD: begin
        // descend toward the offset, then check start and use of the leaf
        if (rdata == MK_SPLIT && lvl != '0) begin
          node_next = cur.roff[lvl_dec] ? node_right : node_left;
          lvl_next  = lvl_dec;
          re        = 1'b1;
          raddr     = cur.roff[lvl_dec] ? node_right : node_left;
        end else if ((cur.roff & low_mask) == '0 && rdata == MK_USED) begin
          res_next   = '{status: STS_OK, offset: cur.roff, order: lvl};
          state_next = ST_REL_FREE;
        end else begin
          res_next   = '{status: STS_BADREL, offset: cur.roff, order: '0};
          state_next = ST_DONE;
        end
      end

      ST_REL_FREE: begin
        we    = 1'b1;
        waddr = node;
        wdata = MK_FREE;
        if (node == NODE_AW'(1)) begin
          state_next = ST_DONE;
        end else begin
          re         = 1'b1;
          raddr      = node_buddy;
          state_next = ST_REL_MERGE;
        end
      end

      ST_REL_MERGE: begin
        if (rdata == MK_FREE) begin
          we         = 1'b1;
          waddr      = node;
          wdata      = MK_ABSENT;
          state_next = ST_REL_PRUNE;
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_REL_PRUNE: begin
        // drop the buddy and continue at the parent
        we         = 1'b1;
        waddr      = node_buddy;
        wdata      = MK_ABSENT;
        node_next  = node_up;
        state_next = ST_REL_FREE;
      end

      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_CLEAR;
      end
    endcase

    // a pool change restarts the clearing sweep
    if (restart) begin
      state_next   = ST_CLEAR;
      clr_cnt_next = '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
    end
  end

  // Walk registers and result
  always_ff @(posedge clk) begin
    node <= node_next;
    lvl  <= lvl_next;
    base <= base_next;
    cur  <= cur_next;
    res  <= res_next;
  end

`ifndef SYNTHESIS
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (we && re) |-> (waddr != raddr))
    else $error("mark RAM read and write hit the same node in one cycle");

  a_split_above_req: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ALLOC_SPLIT) |-> (lvl > cur.req))
    else $error("split started at or below the requested order");

  a_ok_order_fits: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == STS_OK) |-> (res.order <= pool_lvl))
    else $error("good result reports a block larger than the pool");

  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && clr_cnt == '1 && !restart) |=> (state == ST_IDLE))
    else $error("clearing sweep did not end after the last node");
`endif

endmodule
